// ===== src/single_byte_xor_key_search_defines.svh =====
// assertion helpers shared by sxk_pair.sv and single_byte_xor_key_search.sv
`ifndef SINGLE_BYTE_XOR_KEY_SEARCH_DEFINES_SVH
`define SINGLE_BYTE_XOR_KEY_SEARCH_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property checked on every rising edge outside reset
`define SXK_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sxk assertion failed");
// antecedent and consequent given apart, consequent checked in the next cycle
`define SXK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sxk assertion failed");
`else
`define SXK_ASSERT(lbl, clk, rst_n, prop)
`define SXK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/sxk_pkg.sv =====
package sxk_pkg;

  localparam int ScoreBits = 16;
  localparam int KeyCount  = 256;
  localparam int KeyBits   = 8;

  localparam logic [7:0] CharE     = 8'h65;
  localparam logic [7:0] CharA     = 8'h61;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharLowA  = 8'h61;

  typedef logic [ScoreBits-1:0] score_t;

  // ciphertext byte broadcast to the cells
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } sxk_byte_t;

  // control shared by all cells
  typedef struct packed {
    logic shift;
  } sxk_cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_COUNT,
    ST_DRAIN,
    ST_SCAN
  } sxk_state_e;

  // digit value with 8-bit wrap, also for non-hex codes
  function automatic logic [7:0] hex_value(input logic [7:0] c);
    if (c <= CharNine) begin
      return c - CharZero;
    end
    return 8'd10 + c - CharLowA;
  endfunction

endpackage

// ===== src/sxk_if.sv =====
// input channel: one hex character per item
interface sxk_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] hex_char;
  logic       last;

  modport source (output valid, output hex_char, output last, input ready);
  modport sink   (input valid, input hex_char, input last, output ready);
endinterface

// result channel: one item per message
interface sxk_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  best_key;
  logic [15:0] peak_score;
  logic        found;

  modport source (output valid, output best_key, output peak_score, output found,
                  input ready);
  modport sink   (input valid, input best_key, input peak_score, input found,
                  output ready);
endinterface

// ===== src/sxk_pair.sv =====
`include "single_byte_xor_key_search_defines.svh"

module sxk_pair
  import sxk_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] hex_char_i,
  input  logic       last_i,
  output sxk_byte_t  byte_o
);

  logic       phase_q, phase_d;
  logic [3:0] hold_q, hold_d;
  sxk_byte_t  byte_d;
  logic       byte_valid_q;
  logic [7:0] byte_data_q;
  logic [7:0] value;

  assign value = hex_value(hex_char_i);

  // pair digits, drop a trailing first digit at the end of a message
  always_comb begin
    phase_d     = phase_q;
    hold_d      = hold_q;
    byte_d.valid = accept_i && phase_q;
    byte_d.data  = {hold_q, 4'b0000} | value;
    if (accept_i) begin
      if (!phase_q) begin
        hold_d  = value[3:0];
        phase_d = 1'b1;
      end else begin
        phase_d = 1'b0;
      end
      if (last_i) begin
        phase_d = 1'b0;
        hold_d  = 4'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= 1'b0;
      hold_q       <= 4'd0;
      byte_valid_q <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      hold_q       <= hold_d;
      byte_valid_q <= byte_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_data_q <= byte_d.data;
  end

  assign byte_o = '{valid: byte_valid_q, data: byte_data_q};

  `SXK_ASSERT(a_byte_from_second_digit, clk_i, rst_ni, byte_valid_q |-> $past(phase_q))
  `SXK_ASSERT(a_byte_needs_accept, clk_i, rst_ni, byte_valid_q |-> $past(accept_i))
  `SXK_ASSERT_NEXT(a_last_clears_phase, clk_i, rst_ni, accept_i && last_i, !phase_q)

endmodule

// ===== src/sxk_cell.sv =====
module sxk_cell
  import sxk_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [KeyBits-1:0] key_i,
  input  sxk_byte_t          byte_i,
  input  sxk_cell_ctrl_t     ctrl_i,
  input  score_t             next_count_i,
  output score_t             count_o
);

  score_t count_q, count_d;
  logic   hit;

  // this key decrypts the byte to one of the scored characters
  assign hit = byte_i.valid &&
               ((key_i == (byte_i.data ^ CharE)) ||
                (key_i == (byte_i.data ^ CharA)) ||
                (key_i == (byte_i.data ^ CharSpace)));

  // saturating count, or take the neighbor's count while scanning
  always_comb begin
    count_d = count_q;
    if (ctrl_i.shift) begin
      count_d = next_count_i;
    end else if (hit && (count_q != '1)) begin
      count_d = count_q + score_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule

// ===== src/single_byte_xor_key_search.sv =====
// Takes one lower-case hex character per cycle and pairs characters into ciphertext
// bytes; a row of 256 cells, one per key, each counts (saturating) the bytes that
// its key turns into 'e', 'a' or space. After the character marked last the block
// stops taking items while it drains the final byte and scans: the counts shift
// down the cell row one place per cycle past a comparator at its head, which keeps
// the lowest key with the strictly highest non-zero count, and zeros shift in
// behind so the counts are clear for the next message. The result item is loaded
// when the scan ends; the scan starts only once the previous result has been taken.
`include "single_byte_xor_key_search_defines.svh"

module single_byte_xor_key_search
  import sxk_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  sxk_in_if.sink      in_i,
  sxk_out_if.source   out_o
);

  localparam logic [KeyBits-1:0] ScanLast = KeyBits'(KeyCount - 1);

  sxk_state_e               state_q, state_d;
  logic [KeyBits-1:0]       scan_idx_q, scan_idx_d;
  score_t                   best_q, best_d;
  logic [KeyBits-1:0]       best_key_q, best_key_d;
  logic                     out_valid_q, out_valid_d;
  logic [7:0]               out_key_q, out_key_d;
  logic [15:0]              out_score_q, out_score_d;
  logic                     out_found_q, out_found_d;
  logic                     accept;
  logic                     load_out;
  logic                     better;
  logic                     scan_end;
  logic [ScoreBits+15:0]    best_wide;
  sxk_byte_t                byte_bc;
  sxk_cell_ctrl_t           cell_ctrl;
  logic [KeyCount-1:0][ScoreBits-1:0] counts;

  assign in_i.ready = (state_q == ST_COUNT);
  assign accept     = in_i.valid && in_i.ready;

  // digit pairing
  sxk_pair u_pair (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .hex_char_i (in_i.hex_char),
    .last_i     (in_i.last),
    .byte_o     (byte_bc)
  );

  // row of key cells, counts move toward key 0 while scanning
  for (genvar g = 0; g < KeyCount; g++) begin : g_cell
    score_t next_count;
    if (g == KeyCount - 1) begin : g_tail
      assign next_count = '0;
    end else begin : g_mid
      assign next_count = counts[g+1];
    end
    sxk_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .key_i        (KeyBits'(g)),
      .byte_i       (byte_bc),
      .ctrl_i       (cell_ctrl),
      .next_count_i (next_count),
      .count_o      (counts[g])
    );
  end

  // head comparator
  assign better = counts[0] > best_q;

  // last scan cycle
  assign scan_end = (state_q == ST_SCAN) && (scan_idx_q == ScanLast);

  // sequencer
  always_comb begin
    state_d         = state_q;
    scan_idx_d      = scan_idx_q;
    best_d          = best_q;
    best_key_d      = best_key_q;
    cell_ctrl.shift = 1'b0;
    load_out        = 1'b0;
    case (state_q)
      ST_COUNT: begin
        if (accept && in_i.last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // final byte lands in the cells here; wait for a free result slot
        scan_idx_d = '0;
        best_d     = '0;
        best_key_d = '0;
        if (!out_valid_q) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cell_ctrl.shift = 1'b1;
        scan_idx_d      = scan_idx_q + KeyBits'(1);
        if (better) begin
          best_d     = counts[0];
          best_key_d = scan_idx_q;
        end
        if (scan_idx_q == ScanLast) begin
          load_out = 1'b1;
          state_d  = ST_COUNT;
        end
      end
      default: begin
        state_d = ST_COUNT;
      end
    endcase
  end

  // result register
  assign best_wide = {16'd0, best_d};

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    out_key_d   = out_key_q;
    out_score_d = out_score_q;
    out_found_d = out_found_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_key_d   = best_key_d;
      out_score_d = best_wide[15:0];
      out_found_d = (best_d != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_COUNT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_idx_q  <= scan_idx_d;
    best_q      <= best_d;
    best_key_q  <= best_key_d;
    out_key_q   <= out_key_d;
    out_score_q <= out_score_d;
    out_found_q <= out_found_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.best_key   = out_key_q;
  assign out_o.peak_score = out_score_q;
  assign out_o.found      = out_found_q;

  `SXK_ASSERT(a_result_after_scan, clk_i, rst_ni, $rose(out_valid_q) |-> $past(scan_end))
  `SXK_ASSERT_NEXT(a_scan_clears_counts, clk_i, rst_ni, scan_end, counts == '0)
  `SXK_ASSERT(a_no_count_while_shifting, clk_i, rst_ni, (state_q == ST_SCAN) |-> !byte_bc.valid)

endmodule
